@@ hdl/c16ls_pkg.sv @@
`default_nettype none

package c16ls_pkg;

	// instruction codes
	localparam logic [3:0] OP_LD_BC     = 4'd0;
	localparam logic [3:0] OP_LD_DE     = 4'd1;
	localparam logic [3:0] OP_LD_HL     = 4'd2;
	localparam logic [3:0] OP_LD_SP     = 4'd3;
	localparam logic [3:0] OP_LD_NN_SP  = 4'd4;
	localparam logic [3:0] OP_PUSH_BC   = 4'd5;
	localparam logic [3:0] OP_PUSH_AF   = 4'd8;
	localparam logic [3:0] OP_POP_BC    = 4'd9;
	localparam logic [3:0] OP_POP_AF    = 4'd12;
	localparam logic [3:0] OP_LD_SP_HL  = 4'd13;

	// register file slots: B,C,D,E,H,L,A,F
	localparam logic [2:0] REG_H = 3'd4;
	localparam logic [2:0] REG_L = 3'd5;
	localparam logic [1:0] PAIR_AF = 2'd3;

	typedef struct packed {
		logic [7:0][7:0] regs;
		logic [15:0]     pc;
		logic [15:0]     sp;
		logic [15:0]     tmp;
	} arch_t;

	typedef struct packed {
		logic [15:0] addr;
		logic        rd;
		logic        wr;
		logic [7:0]  wb;
		logic        done;
	} result_t;

endpackage

`default_nettype wire

@@ hdl/cpu_16bit_load_stack_executor.sv @@
// 16-bit load / stack group executor, one CPU machine cycle per request.
// Input channel (in_valid/in_ready) carries instr_code, cycle_index and the
// memory byte read in that cycle. Output channel (out_valid/out_ready) gives
// the bus access of the cycle, the done flag and PC, SP and the register
// pairs as they stand after the cycle.
// The request passes through the input register, then the result register.
// Throughput: one request per cycle while the receiver does not stall; the
// register file, PC and SP are updated in the same cycle that loads the
// result, so the next request sees them straight away.
// When the receiver stalls, the result and the architectural state hold and
// one further request is taken into the input register; in_ready drops once
// both stages are full.
// Reset clears both stage valids, all registers, PC, SP and the address
// latch to zero. Codes 14 and 15 give an idle cycle with no state change.
`default_nettype none

module cpu_16bit_load_stack_executor
	import c16ls_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  instr_code,
	input  wire logic [2:0]  cycle_index,
	input  wire logic [7:0]  read_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      bus_addr,
	output logic             bus_read,
	output logic             bus_write,
	output logic [7:0]       write_byte,
	output logic             finished,
	output logic [15:0]      prog_counter,
	output logic [15:0]      stack_ptr,
	output logic [15:0]      pair_bc,
	output logic [15:0]      pair_de,
	output logic [15:0]      pair_hl,
	output logic [15:0]      pair_af
);

	logic        valid_s1;
	logic [3:0]  instr_code_s1;
	logic [2:0]  cycle_index_s1;
	logic [7:0]  read_byte_s1;
	logic        valid_s2;
	result_t     res_s2;
	arch_t       arch_q;
	arch_t       arch_nxt;
	result_t     res_nxt;
	logic        s2_free;
	logic        adv;

	assign s2_free  = !valid_s2 || out_ready;
	assign adv      = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	c16ls_exec u_exec (
		.cur         (arch_q),
		.instr_code  (instr_code_s1),
		.cycle_index (cycle_index_s1),
		.read_byte   (read_byte_s1),
		.nxt         (arch_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			instr_code_s1  <= instr_code;
			cycle_index_s1 <= cycle_index;
			read_byte_s1   <= read_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			res_s2   <= '0;
			arch_q   <= '0;
		end else begin
			if (s2_free)
				valid_s2 <= valid_s1;
			if (adv) begin
				res_s2 <= res_nxt;
				arch_q <= arch_nxt;
			end
		end
	end

	assign out_valid    = valid_s2;
	assign bus_addr     = res_s2.addr;
	assign bus_read     = res_s2.rd;
	assign bus_write    = res_s2.wr;
	assign write_byte   = res_s2.wb;
	assign finished     = res_s2.done;
	assign prog_counter = arch_q.pc;
	assign stack_ptr    = arch_q.sp;
	assign pair_bc      = {arch_q.regs[0], arch_q.regs[1]};
	assign pair_de      = {arch_q.regs[2], arch_q.regs[3]};
	assign pair_hl      = {arch_q.regs[4], arch_q.regs[5]};
	assign pair_af      = {arch_q.regs[6], arch_q.regs[7]};

`ifndef SYNTHESIS
	a_no_rd_and_wr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(bus_read && bus_write))
		else $error("read and write in the same cycle");

	a_wb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bus_write |-> write_byte == 8'd0)
		else $error("write byte set without a write");

	a_pc_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		prog_counter != $past(prog_counter) |-> out_valid && finished)
		else $error("PC moved without a finishing cycle");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(stack_ptr) && $stable(prog_counter)
			&& $stable(pair_af))
		else $error("state changed while result stalled");
`endif

endmodule

`default_nettype wire

@@ hdl/c16ls_exec.sv @@
`default_nettype none

module c16ls_exec
	import c16ls_pkg::*;
(
	input  arch_t       cur,
	input  logic [3:0]  instr_code,
	input  logic [2:0]  cycle_index,
	input  logic [7:0]  read_byte,
	output arch_t       nxt,
	output result_t     res
);

	logic [3:0] push_off;
	logic [3:0] pop_off;
	logic [1:0] push_pair;
	logic [1:0] pop_pair;
	logic [1:0] ld_pair;

	assign push_off  = instr_code - OP_PUSH_BC;
	assign pop_off   = instr_code - OP_POP_BC;
	assign push_pair = push_off[1:0];
	assign pop_pair  = pop_off[1:0];
	assign ld_pair   = instr_code[1:0];

	always_comb begin
		nxt = cur;
		res = '0;
		case (instr_code) inside
			[OP_LD_BC:OP_LD_HL]: begin
				if (cycle_index == 3'd1) begin
					res.addr = cur.pc + 16'd1;
					res.rd   = 1'b1;
					nxt.regs[{ld_pair, 1'b1}] = read_byte;
				end else if (cycle_index >= 3'd2) begin
					if (cycle_index == 3'd2) begin
						res.addr = cur.pc + 16'd2;
						res.rd   = 1'b1;
						nxt.regs[{ld_pair, 1'b0}] = read_byte;
					end
					nxt.pc   = cur.pc + 16'd3;
					res.done = 1'b1;
				end
			end
			OP_LD_SP: begin
				if (cycle_index == 3'd1) begin
					res.addr = cur.pc + 16'd1;
					res.rd   = 1'b1;
					nxt.sp   = {cur.sp[15:8], read_byte};
				end else if (cycle_index >= 3'd2) begin
					if (cycle_index == 3'd2) begin
						res.addr = cur.pc + 16'd2;
						res.rd   = 1'b1;
						nxt.sp   = {read_byte, cur.sp[7:0]};
					end
					nxt.pc   = cur.pc + 16'd3;
					res.done = 1'b1;
				end
			end
			OP_LD_NN_SP: begin
				if (cycle_index == 3'd1) begin
					res.addr = cur.pc + 16'd1;
					res.rd   = 1'b1;
					nxt.tmp  = {8'd0, read_byte};
				end else if (cycle_index == 3'd2) begin
					res.addr = cur.pc + 16'd2;
					res.rd   = 1'b1;
					nxt.tmp  = {read_byte, cur.tmp[7:0]};
				end else if (cycle_index == 3'd3) begin
					res.addr = cur.tmp;
					res.wr   = 1'b1;
					res.wb   = cur.sp[7:0];
				end else if (cycle_index >= 3'd4) begin
					if (cycle_index == 3'd4) begin
						res.addr = cur.tmp + 16'd1;
						res.wr   = 1'b1;
						res.wb   = cur.sp[15:8];
					end
					nxt.pc   = cur.pc + 16'd3;
					res.done = 1'b1;
				end
			end
			[OP_PUSH_BC:OP_PUSH_AF]: begin
				if (cycle_index == 3'd2) begin
					nxt.sp   = cur.sp - 16'd1;
					res.addr = cur.sp - 16'd1;
					res.wr   = 1'b1;
					res.wb   = cur.regs[{push_pair, 1'b0}];
				end else if (cycle_index >= 3'd3) begin
					if (cycle_index == 3'd3) begin
						nxt.sp   = cur.sp - 16'd1;
						res.addr = cur.sp - 16'd1;
						res.wr   = 1'b1;
						res.wb   = cur.regs[{push_pair, 1'b1}];
					end
					nxt.pc   = cur.pc + 16'd1;
					res.done = 1'b1;
				end
			end
			[OP_POP_BC:OP_POP_AF]: begin
				if (cycle_index == 3'd1) begin
					res.addr = cur.sp;
					res.rd   = 1'b1;
					// low nibble of F always reads as zero
					nxt.regs[{pop_pair, 1'b1}] = (pop_pair == PAIR_AF) ?
						{read_byte[7:4], 4'd0} : read_byte;
					nxt.sp   = cur.sp + 16'd1;
				end else if (cycle_index >= 3'd2) begin
					if (cycle_index == 3'd2) begin
						res.addr = cur.sp;
						res.rd   = 1'b1;
						nxt.regs[{pop_pair, 1'b0}] = read_byte;
						nxt.sp   = cur.sp + 16'd1;
					end
					nxt.pc   = cur.pc + 16'd1;
					res.done = 1'b1;
				end
			end
			OP_LD_SP_HL: begin
				if (cycle_index >= 3'd1) begin
					if (cycle_index == 3'd1)
						nxt.sp = {cur.regs[REG_H], cur.regs[REG_L]};
					nxt.pc   = cur.pc + 16'd1;
					res.done = 1'b1;
				end
			end
			default: begin
				nxt = cur;
				res = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sim/c16ls_checker.sv @@
`timescale 1ns / 1ps

module c16ls_checker
	import c16ls_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [3:0]  instr_code,
	input  wire logic [2:0]  cycle_index,
	input  wire logic [7:0]  read_byte,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [15:0] bus_addr,
	input  wire logic        bus_read,
	input  wire logic        bus_write,
	input  wire logic [7:0]  write_byte,
	input  wire logic        finished,
	input  wire logic [15:0] prog_counter,
	input  wire logic [15:0] stack_ptr,
	input  wire logic [15:0] pair_bc,
	input  wire logic [15:0] pair_de,
	input  wire logic [15:0] pair_hl,
	input  wire logic [15:0] pair_af,
	output int               failures,
	output int               pending
);

	localparam logic [1:0] PAIR_BC = 2'd0;
	localparam logic [1:0] PAIR_DE = 2'd1;
	localparam logic [1:0] PAIR_HL = 2'd2;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [15:0] addr;
		logic        rd_en;
		logic        wr_en;
		logic [7:0]  wdata;
		logic        done;
		logic [15:0] pc;
		logic [15:0] sp;
		logic [15:0] bc;
		logic [15:0] de;
		logic [15:0] hl;
		logic [15:0] af;
	} cycle_result_t;

	logic [7:0]    regs [8];
	logic [15:0]   arch_pc;
	logic [15:0]   arch_sp;
	logic [15:0]   addr_latch;
	cycle_result_t expected_cycles [$];
	int            reported;

	function automatic logic [15:0] pair_value(input logic [1:0] sel);
		return {regs[{sel, 1'b0}], regs[{sel, 1'b1}]};
	endfunction

	// advances the shadow CPU state by one machine cycle
	function automatic cycle_result_t execute_cycle(input logic [3:0] code,
			input logic [2:0] cyc, input logic [7:0] mem_byte);
		cycle_result_t r;
		logic [1:0]    sel;
		r = '0;
		sel = '0;
		if (code <= OP_LD_SP) begin
			sel = code[1:0];
			if (cyc == 3'd1) begin
				r.addr = arch_pc + 16'd1;
				r.rd_en = 1'b1;
				if (code == OP_LD_SP)
					arch_sp[7:0] = mem_byte;
				else
					regs[{sel, 1'b1}] = mem_byte;
			end else if (cyc >= 3'd2) begin
				if (cyc == 3'd2) begin
					r.addr = arch_pc + 16'd2;
					r.rd_en = 1'b1;
					if (code == OP_LD_SP)
						arch_sp[15:8] = mem_byte;
					else
						regs[{sel, 1'b0}] = mem_byte;
				end
				arch_pc = arch_pc + 16'd3;
				r.done = 1'b1;
			end
		end else if (code == OP_LD_NN_SP) begin
			if (cyc == 3'd1) begin
				r.addr = arch_pc + 16'd1;
				r.rd_en = 1'b1;
				addr_latch = {8'h00, mem_byte};
			end else if (cyc == 3'd2) begin
				// high address byte comes from pc+2
				r.addr = arch_pc + 16'd2;
				r.rd_en = 1'b1;
				addr_latch[15:8] = mem_byte;
			end else if (cyc == 3'd3) begin
				r.addr = addr_latch;
				r.wr_en = 1'b1;
				r.wdata = arch_sp[7:0];
			end else if (cyc >= 3'd4) begin
				if (cyc == 3'd4) begin
					r.addr = addr_latch + 16'd1;
					r.wr_en = 1'b1;
					r.wdata = arch_sp[15:8];
				end
				arch_pc = arch_pc + 16'd3;
				r.done = 1'b1;
			end
		end else if (code <= OP_PUSH_AF) begin
			sel = 2'(code - OP_PUSH_BC);
			if (cyc == 3'd2) begin
				arch_sp = arch_sp - 16'd1;
				r.addr = arch_sp;
				r.wr_en = 1'b1;
				r.wdata = regs[{sel, 1'b0}];
			end else if (cyc >= 3'd3) begin
				if (cyc == 3'd3) begin
					arch_sp = arch_sp - 16'd1;
					r.addr = arch_sp;
					r.wr_en = 1'b1;
					r.wdata = regs[{sel, 1'b1}];
				end
				arch_pc = arch_pc + 16'd1;
				r.done = 1'b1;
			end
		end else if (code <= OP_POP_AF) begin
			sel = 2'(code - OP_POP_BC);
			if (cyc == 3'd1) begin
				r.addr = arch_sp;
				r.rd_en = 1'b1;
				// low nibble of F always reads as zero
				regs[{sel, 1'b1}] = (sel == PAIR_AF) ? (mem_byte & 8'hF0) : mem_byte;
				arch_sp = arch_sp + 16'd1;
			end else if (cyc >= 3'd2) begin
				if (cyc == 3'd2) begin
					r.addr = arch_sp;
					r.rd_en = 1'b1;
					regs[{sel, 1'b0}] = mem_byte;
					arch_sp = arch_sp + 16'd1;
				end
				arch_pc = arch_pc + 16'd1;
				r.done = 1'b1;
			end
		end else if (code == OP_LD_SP_HL) begin
			if (cyc >= 3'd1) begin
				if (cyc == 3'd1)
					arch_sp = pair_value(PAIR_HL);
				arch_pc = arch_pc + 16'd1;
				r.done = 1'b1;
			end
		end
		r.pc = arch_pc;
		r.sp = arch_sp;
		r.bc = pair_value(PAIR_BC);
		r.de = pair_value(PAIR_DE);
		r.hl = pair_value(PAIR_HL);
		r.af = pair_value(PAIR_AF);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			failures++;
			if (reported < REPORT_LIMIT) begin
				reported++;
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cycle_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				regs[i] = '0;
			arch_pc = '0;
			arch_sp = '0;
			addr_latch = '0;
			expected_cycles.delete();
			failures = 0;
			reported = 0;
			pending <= 0;
		end else begin
			// compare before predicting: a result never belongs to a request taken this edge
			if (out_valid && out_ready) begin
				if (expected_cycles.size() == 0) begin
					failures++;
					if (reported < REPORT_LIMIT) begin
						reported++;
						$display("%0t: result with no request pending, addr %h", $realtime,
							bus_addr);
					end
				end else begin
					want = expected_cycles.pop_front();
					check_field("bus_addr", want.addr, bus_addr);
					check_field("bus_read", want.rd_en, bus_read);
					check_field("bus_write", want.wr_en, bus_write);
					check_field("write_byte", want.wdata, write_byte);
					check_field("finished", want.done, finished);
					check_field("prog_counter", want.pc, prog_counter);
					check_field("stack_ptr", want.sp, stack_ptr);
					check_field("pair_bc", want.bc, pair_bc);
					check_field("pair_de", want.de, pair_de);
					check_field("pair_hl", want.hl, pair_hl);
					check_field("pair_af", want.af, pair_af);
				end
			end
			if (in_valid && in_ready)
				expected_cycles.push_back(execute_cycle(instr_code, cycle_index, read_byte));
			pending <= expected_cycles.size();
		end
	end

endmodule

@@ sim/cpu_16bit_load_stack_executor_tb.sv @@
`timescale 1ns / 1ps

module cpu_16bit_load_stack_executor_tb
	import c16ls_pkg::*;
();

	localparam logic [3:0] OP_SPARE_E = 4'd14;
	localparam logic [3:0] OP_SPARE_F = 4'd15;
	localparam int RANDOM_ITEMS = 450;
	localparam int CALM_AFTER = 380;
	localparam int HOLD_AFTER = 60;
	localparam int HOLD_CYCLES = 50;
	localparam int CYCLE_LIMIT = 100000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  instr_code = '0;
	logic [2:0]  cycle_index = '0;
	logic [7:0]  read_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] bus_addr;
	logic        bus_read;
	logic        bus_write;
	logic [7:0]  write_byte;
	logic        finished;
	logic [15:0] prog_counter;
	logic [15:0] stack_ptr;
	logic [15:0] pair_bc;
	logic [15:0] pair_de;
	logic [15:0] pair_hl;
	logic [15:0] pair_af;
	int          failures;
	int          pending;

	int          requests_sent = 0;
	int          cycle_count = 0;
	bit          calm = 1'b0;
	bit          hold_done = 1'b0;

	cpu_16bit_load_stack_executor u_dut (.*);

	c16ls_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	// receiver: short random stalls, one long hold-off to back the block up
	initial begin
		@(posedge clk iff arst_n);
		forever begin
			if (!hold_done && requests_sent >= HOLD_AFTER) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	task automatic send_request(input logic [3:0] code, input logic [2:0] cyc,
			input logic [7:0] mem_byte);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		instr_code <= code;
		cycle_index <= cyc;
		read_byte <= mem_byte;
		do
			@(posedge clk);
		while (!in_ready);
		requests_sent++;
	endtask

	// one instruction cycle by cycle; sometimes cut short or ended past its plan
	task automatic run_instruction(input logic [3:0] code, inout int counted);
		int last_cyc;
		int stop_at;
		if (code <= OP_LD_SP)
			last_cyc = 2;
		else if (code == OP_LD_NN_SP)
			last_cyc = 4;
		else if (code <= OP_PUSH_AF)
			last_cyc = 3;
		else if (code <= OP_POP_AF)
			last_cyc = 2;
		else
			last_cyc = 1;
		stop_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, last_cyc) : last_cyc;
		for (int k = 0; k <= stop_at; k++) begin
			if (k == last_cyc && $urandom_range(0, 9) == 0)
				send_request(code, 3'($urandom_range(last_cyc + 1, 7)), 8'($urandom));
			else
				send_request(code, 3'(k), 8'($urandom));
			counted++;
		end
	endtask

	initial begin
		int counted;
		logic [3:0] code;
		counted = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// SP to all ones, then push and pop AF around it
		send_request(OP_LD_SP, 3'd0, 8'h00);
		send_request(OP_LD_SP, 3'd1, 8'hFF);
		send_request(OP_LD_SP, 3'd2, 8'hFF);
		for (int k = 0; k < 4; k++)
			send_request(OP_PUSH_AF, 3'(k), 8'h00);
		send_request(OP_POP_AF, 3'd0, 8'h00);
		send_request(OP_POP_AF, 3'd1, 8'hFF);
		send_request(OP_POP_AF, 3'd2, 8'hFF);
		// HL = 0, SP = HL, then push wraps SP below zero
		send_request(OP_LD_HL, 3'd0, 8'hFF);
		send_request(OP_LD_HL, 3'd1, 8'h00);
		send_request(OP_LD_HL, 3'd2, 8'h00);
		send_request(OP_LD_SP_HL, 3'd0, 8'h00);
		send_request(OP_LD_SP_HL, 3'd1, 8'h00);
		send_request(OP_PUSH_BC, 3'd2, 8'h00);
		send_request(OP_PUSH_BC, 3'd3, 8'h00);
		// store to 0xFFFF so the second byte wraps to 0x0000
		send_request(OP_LD_NN_SP, 3'd1, 8'hFF);
		send_request(OP_LD_NN_SP, 3'd2, 8'hFF);
		send_request(OP_LD_NN_SP, 3'd3, 8'h00);
		send_request(OP_LD_NN_SP, 3'd4, 8'h00);
		// cycles beyond the plan, and spare codes
		send_request(OP_LD_DE, 3'd7, 8'hA5);
		send_request(OP_LD_SP_HL, 3'd5, 8'h5A);
		send_request(OP_SPARE_E, 3'd1, 8'hFF);
		send_request(OP_SPARE_F, 3'd3, 8'hFF);

		while (counted < RANDOM_ITEMS) begin
			calm = (counted >= CALM_AFTER);
			if ($urandom_range(0, 9) < 8) begin
				run_instruction(4'($urandom_range(0, 13)), counted);
			end else begin
				code = 4'($urandom_range(0, 15));
				send_request(code, 3'($urandom_range(0, 7)), 8'($urandom));
				if (code <= OP_LD_SP_HL)
					counted++;
			end
		end
		in_valid <= 1'b0;

		do
			@(posedge clk);
		while (pending != 0);
		repeat (10) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
